>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define PVA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pva_pkg.sv
package pva_pkg;

  localparam int MAX_VOICES = 16;
  localparam int VIDX_W     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W      = $clog2(MAX_VOICES + 1);
  localparam int AGE_W      = 64;
  localparam int VC_W       = 5;
  localparam logic [VC_W-1:0] VC_RESET = VC_W'(16);
  localparam logic [6:0] NOTE_RESET = 7'd60;

  typedef enum logic [1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_QUIET    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_FREE      = 2'd0,
    ACT_HELD      = 2'd1,
    ACT_RELEASING = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } st_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [3:0] quiet_voice;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] voice;
    logic       gate;
    logic       retrigger;
    logic [6:0] note_out;
    logic [6:0] velocity_out;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan;
    logic last;
  } dp_status_t;

  // Voice index as reported on the result: low four bits.
  function automatic logic [3:0] voice_field(input logic [VIDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[3:0];
  endfunction

endpackage

>>> rtl/poly_voice_allocator.sv
// Polyphonic voice allocator.
// Input channel (in_valid_i / in_ready_o / in_item_i): one beat per note event:
// note-on, note-off, or the end of a voice's release. Output channel
// (out_valid_o / out_ready_i / out_item_o): exactly one result beat per event;
// events with no voice change to report (rejected note-off, quiet event, unused
// command) give a beat with every field zero.
// Steps: a note-on or note-off is accepted, then the voice table is scanned
// over its active voices (voice_count, clamped to 1..MAX_VOICES), then the
// result is committed. A quiet event is accepted and committed with no scan step.
// The result is valid the cycle after commit. The single age comparator in the
// scan sets the rate: one voice per cycle.
// The block takes one event at a time; in_ready_o is high only while idle.
// A finished result waits in the output register; the next event is accepted
// and scanned meanwhile, and its commit holds until the receiver takes the
// waiting beat.
// cfg_we_i / cfg_wdata_i write voice_count; write it only while idle.
// Reset clears all voices to free, silent, age zero, note 60, the age counter
// to one and voice_count to 16.
module poly_voice_allocator (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pva_pkg::in_item_t      in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pva_pkg::out_item_t     out_item_o,
  input  logic                   cfg_we_i,
  input  logic [pva_pkg::VC_W-1:0] cfg_wdata_i
);

`include "assert_macros.svh"

  pva_pkg::ctl_cmd_t   ctl_cmd;
  pva_pkg::dp_status_t dp_status;

  // sequencing: accept, scan, commit
  pva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (ctl_cmd)
  );

  // voice table, trackers and result register
  pva_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (ctl_cmd),
    .status_o    (dp_status),
    .out_item_o  (out_item_o)
  );

  // Commit never overwrites a result that is still waiting.
  `PVA_ASSERT(a_commit_free, clk_i, rst_ni, ctl_cmd.commit |-> (!out_valid_o || out_ready_i), "commit while output is occupied")
  // After an accepted beat the block is busy.
  `PVA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")
  // No scan step or commit while the input side is open.
  `PVA_ASSERT(a_idle_quiet, clk_i, rst_ni, in_ready_o |-> (!ctl_cmd.step && !ctl_cmd.commit), "work while idle")
  // A retrigger or a gate comes only with an accepted voice change.
  `PVA_ASSERT(a_flags_consistent, clk_i, rst_ni, out_valid_o && (out_item_o.gate || out_item_o.retrigger) |-> (out_item_o.accepted && (out_item_o.gate || !out_item_o.retrigger)), "gate or retrigger without a voice change")

endmodule

>>> rtl/pva_ctrl.sv
module pva_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pva_pkg::dp_status_t   status_i,
  output pva_pkg::ctl_cmd_t     cmd_o
);

  pva_pkg::st_e state_q, state_d;
  logic         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pva_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pva_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pva_pkg::ST_SCAN;
        end
      end
      pva_pkg::ST_SCAN: begin
        if (!status_i.scan) begin
          state_d = pva_pkg::ST_COMMIT;
        end else begin
          cmd_o.step = 1'b1;
          if (status_i.last) state_d = pva_pkg::ST_COMMIT;
        end
      end
      pva_pkg::ST_COMMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = pva_pkg::ST_IDLE;
        end
      end
      default: state_d = pva_pkg::ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/pva_datapath.sv
module pva_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pva_pkg::in_item_t     in_item_i,
  input  logic                  cfg_we_i,
  input  logic [pva_pkg::VC_W-1:0] cfg_wdata_i,
  input  pva_pkg::ctl_cmd_t     cmd_i,
  output pva_pkg::dp_status_t   status_o,
  output pva_pkg::out_item_t    out_item_o
);

  localparam int NV = pva_pkg::MAX_VOICES;
  localparam int IW = pva_pkg::VIDX_W;
  localparam int CW = pva_pkg::CNT_W;
  localparam int AW = pva_pkg::AGE_W;

  logic [6:0]       note_q [NV];
  logic             snd_q  [NV];
  logic [AW-1:0]    age_q  [NV];
  pva_pkg::act_e    act_q  [NV];
  logic [AW-1:0]    next_age_q;
  logic [pva_pkg::VC_W-1:0] vc_q;

  pva_pkg::in_item_t  item_q;
  pva_pkg::out_item_t out_q, out_d;
  logic [IW-1:0]      idx_q;

  // scan trackers: first free voice, oldest idle voice, oldest sounding voice (with the event's note on note-off)
  logic          free_found_q, ns_found_q, s_found_q;
  logic [IW-1:0] free_idx_q, ns_idx_q, s_idx_q;
  logic [AW-1:0] ns_age_q, s_age_q;

  logic [CW-1:0] n_active;
  logic [IW-1:0] last_idx;
  logic          rd_snd;
  logic [6:0]    rd_note;
  logic [AW-1:0] rd_age, cmp_age;
  pva_pkg::act_e rd_act;
  logic          age_lt, is_on, is_off, track_ns, track_s, take_free;
  logic [IW-1:0] v_on;
  logic          quiet_ok;

  always_comb begin
    if (vc_q == '0) n_active = CW'(1);
    else if (32'(vc_q) > 32'(NV)) n_active = CW'(NV);
    else n_active = CW'(vc_q);
  end

  assign last_idx = IW'(n_active - CW'(1));

  assign rd_snd  = snd_q[idx_q];
  assign rd_note = note_q[idx_q];
  assign rd_age  = age_q[idx_q];
  assign rd_act  = act_q[idx_q];
  assign cmp_age = rd_snd ? s_age_q : ns_age_q;
  assign age_lt  = rd_age < cmp_age;

  assign is_on  = (item_q.cmd == pva_pkg::CMD_NOTE_ON);
  assign is_off = (item_q.cmd == pva_pkg::CMD_NOTE_OFF);

  assign take_free = is_on && !rd_snd && (rd_act == pva_pkg::ACT_FREE) && !free_found_q;
  assign track_ns  = is_on && !rd_snd && (!ns_found_q || age_lt);
  assign track_s   = rd_snd && (is_on || (is_off && rd_note == item_q.note))
                     && (!s_found_q || age_lt);

  assign status_o.scan = is_on || is_off;
  assign status_o.last = (idx_q == last_idx);

  assign v_on = free_found_q ? free_idx_q : (ns_found_q ? ns_idx_q : s_idx_q);
  assign quiet_ok = (32'(item_q.quiet_voice) < 32'(NV)) && (rd_act == pva_pkg::ACT_RELEASING);

  always_comb begin
    out_d = '0;
    case (item_q.cmd)
      pva_pkg::CMD_NOTE_ON: begin
        out_d.accepted     = 1'b1;
        out_d.voice        = pva_pkg::voice_field(v_on);
        out_d.gate         = 1'b1;
        out_d.retrigger    = !free_found_q && !ns_found_q;
        out_d.note_out     = item_q.note;
        out_d.velocity_out = item_q.velocity;
      end
      pva_pkg::CMD_NOTE_OFF: begin
        if (s_found_q) begin
          out_d.accepted = 1'b1;
          out_d.voice    = pva_pkg::voice_field(s_idx_q);
          out_d.note_out = item_q.note;
        end
      end
      default: out_d = '0;
    endcase
  end

  // Item capture and scan trackers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q       <= in_item_i;
      idx_q        <= (in_item_i.cmd == pva_pkg::CMD_QUIET) ? IW'(in_item_i.quiet_voice) : '0;
      free_found_q <= 1'b0;
      ns_found_q   <= 1'b0;
      s_found_q    <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IW'(1);
      if (take_free) begin
        free_found_q <= 1'b1;
        free_idx_q   <= idx_q;
      end
      if (track_ns) begin
        ns_found_q <= 1'b1;
        ns_idx_q   <= idx_q;
        ns_age_q   <= rd_age;
      end
      if (track_s) begin
        s_found_q <= 1'b1;
        s_idx_q   <= idx_q;
        s_age_q   <= rd_age;
      end
    end
    if (cmd_i.commit) out_q <= out_d;
  end

  // Voice table, age counter and voice count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        note_q[i] <= pva_pkg::NOTE_RESET;
        snd_q[i]  <= 1'b0;
        age_q[i]  <= '0;
        act_q[i]  <= pva_pkg::ACT_FREE;
      end
      next_age_q <= AW'(1);
      vc_q       <= pva_pkg::VC_RESET;
    end else begin
      if (cfg_we_i) vc_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        case (item_q.cmd)
          pva_pkg::CMD_NOTE_ON: begin
            note_q[v_on] <= item_q.note;
            snd_q[v_on]  <= 1'b1;
            age_q[v_on]  <= next_age_q;
            act_q[v_on]  <= pva_pkg::ACT_HELD;
            next_age_q   <= next_age_q + AW'(1);
          end
          pva_pkg::CMD_NOTE_OFF: begin
            if (s_found_q) begin
              snd_q[s_idx_q] <= 1'b0;
              act_q[s_idx_q] <= pva_pkg::ACT_RELEASING;
            end
          end
          pva_pkg::CMD_QUIET: begin
            if (quiet_ok) act_q[idx_q] <= pva_pkg::ACT_FREE;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_item_o = out_q;

endmodule
